// ----- design/cce_pkg.sv -----
package cce_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;
  localparam int unsigned QCW    = 2;

  localparam logic [31:0] START_MAX = 32'h0FFF_FFF6;
  localparam logic [27:0] EOC_ABOVE = 28'hFFF_FFF6;

  typedef enum logic [0:0] {
    CFG_TOTAL_CLUSTERS = 1'b0,
    CFG_CLUSTER_SHIFT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NEED     = 3'd1,
    ST_DONE     = 3'd2,
    ST_BROKEN   = 3'd3,
    ST_BADSTART = 3'd4,
    ST_FULL     = 3'd5,
    ST_PASTEND  = 3'd6,
    ST_IDLE     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_BADSTART = 3'd1,
    OP_ENTRY    = 3'd2,
    OP_EOC      = 3'd3,
    OP_LOOKUP   = 3'd4,
    OP_NOP      = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [27:0] fetch_cluster;
    logic [6:0]  extent_count;
    logic [27:0] mapped_cluster;
    logic [27:0] run_remaining;
  } rsp_t;

  // classified item: arg is cluster, masked entry or cluster index
  typedef struct packed {
    op_kind_t    kind;
    logic [27:0] arg;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

// ----- design/cce_ram.sv -----
module cce_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/cce_front.sv -----
module cce_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cce_pkg::req_t  req,
  input  logic [2:0]     sector_shift,
  input  logic           pop,
  output logic           busy,
  output cce_pkg::q_head_t head
);
  import cce_pkg::*;

  op_t            op_in;
  op_t            queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           do_pop;
  logic [22:0]    order;

  assign order = req.value[31:9] >> sector_shift;

  always_comb begin
    op_in.arg  = '0;
    op_in.kind = OP_NOP;
    case (req.cmd)
      CMD_START: begin
        op_in.arg = req.value[27:0];
        if (req.value < 32'd2 || req.value > START_MAX) begin
          op_in.kind = OP_BADSTART;
        end else begin
          op_in.kind = OP_START;
        end
      end
      CMD_ENTRY: begin
        // reserved top nibble of a fat32 entry is dropped
        op_in.arg  = req.value[27:0];
        op_in.kind = (req.value[27:0] > EOC_ABOVE) ? OP_EOC : OP_ENTRY;
      end
      CMD_LOOKUP: begin
        op_in.arg  = {5'd0, order};
        op_in.kind = OP_LOOKUP;
      end
      default: begin
        op_in.kind = OP_NOP;
      end
    endcase
  end

  assign busy   = (count == QCW'(QDEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = queue[rd_ptr];

endmodule

// ----- design/cce_back.sv -----
module cce_back #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  cce_pkg::q_head_t head,
  input  logic [27:0]      total_clusters,
  output logic             pop,
  output logic             done,
  output cce_pkg::rsp_t    rsp
);
  import cce_pkg::*;

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WALK = 2'b10
  } bstate_t;

  bstate_t       state, state_next;
  logic          building, building_next;
  logic [27:0]   link_cluster, link_cluster_next;
  logic [27:0]   cur_start, cur_start_next;
  logic [27:0]   cur_extra, cur_extra_next;
  logic [CW-1:0] run_index, run_index_next;
  logic [AW-1:0] walk_idx, walk_idx_next;
  logic [27:0]   order, order_next;
  logic          done_next;
  rsp_t          rsp_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [55:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [55:0]   ram_rdata;

  logic [27:0]   rd_start;
  logic [27:0]   rd_extra;
  logic [CW-1:0] next_idx;
  logic [28:0]   succ;
  logic [31:0]   count_wide;

  cce_ram #(
    .WIDTH (56),
    .DEPTH (MAX_EXTENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_start   = ram_rdata[55:28];
  assign rd_extra   = ram_rdata[27:0];
  assign next_idx   = CW'(walk_idx) + 1'b1;
  assign succ       = {1'b0, link_cluster} + 29'd1;
  assign count_wide = 32'(run_index_next);

  always_comb begin
    state_next        = state;
    building_next     = building;
    link_cluster_next = link_cluster;
    cur_start_next    = cur_start;
    cur_extra_next    = cur_extra;
    run_index_next    = run_index;
    walk_idx_next     = walk_idx;
    order_next        = order;
    done_next         = 1'b0;
    pop               = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = '0;
    ram_raddr         = '0;
    rsp_next          = '0;
    rsp_next.status   = ST_IDLE;

    case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          done_next = 1'b1;
          case (head.op.kind)
            OP_START: begin
              ram_we            = 1'b1;
              ram_waddr         = '0;
              ram_wdata         = {head.op.arg, 28'd0};
              cur_start_next    = head.op.arg;
              cur_extra_next    = '0;
              link_cluster_next = head.op.arg;
              run_index_next    = CW'(1);
              building_next     = 1'b1;
              rsp_next.status   = ST_NEED;
              rsp_next.fetch_cluster = head.op.arg;
            end
            OP_BADSTART: begin
              run_index_next  = '0;
              building_next   = 1'b0;
              rsp_next.status = ST_BADSTART;
            end
            OP_EOC: begin
              if (building) begin
                building_next   = 1'b0;
                rsp_next.status = ST_DONE;
              end
            end
            OP_ENTRY: begin
              if (building) begin
                if ({1'b0, head.op.arg} == succ) begin
                  // next in line: grow the open run
                  cur_extra_next    = cur_extra + 1'b1;
                  ram_we            = 1'b1;
                  ram_waddr         = AW'(run_index - 1'b1);
                  ram_wdata         = {cur_start, cur_extra + 28'd1};
                  link_cluster_next = head.op.arg;
                  rsp_next.status   = ST_NEED;
                  rsp_next.fetch_cluster = head.op.arg;
                end else if (head.op.arg < total_clusters) begin
                  if (run_index >= CW'(MAX_EXTENTS)) begin
                    building_next   = 1'b0;
                    rsp_next.status = ST_FULL;
                  end else begin
                    ram_we            = 1'b1;
                    ram_waddr         = AW'(run_index);
                    ram_wdata         = {head.op.arg, 28'd0};
                    cur_start_next    = head.op.arg;
                    cur_extra_next    = '0;
                    run_index_next    = run_index + 1'b1;
                    link_cluster_next = head.op.arg;
                    rsp_next.status   = ST_NEED;
                    rsp_next.fetch_cluster = head.op.arg;
                  end
                end else begin
                  building_next   = 1'b0;
                  rsp_next.status = ST_BROKEN;
                end
              end
            end
            OP_LOOKUP: begin
              if (run_index == '0) begin
                rsp_next.status = ST_PASTEND;
              end else begin
                // first run is read now, result comes from the walk
                done_next     = 1'b0;
                ram_raddr     = '0;
                walk_idx_next = '0;
                order_next    = head.op.arg;
                state_next    = B_WALK;
              end
            end
            default: begin
              rsp_next.status = ST_IDLE;
            end
          endcase
        end
      end
      B_WALK: begin
        if (order <= rd_extra) begin
          done_next               = 1'b1;
          rsp_next.status         = ST_OK;
          rsp_next.mapped_cluster = rd_start + order;
          rsp_next.run_remaining  = rd_extra - order;
          state_next              = B_IDLE;
        end else if (next_idx >= run_index) begin
          done_next       = 1'b1;
          rsp_next.status = ST_PASTEND;
          state_next      = B_IDLE;
        end else begin
          order_next    = order - rd_extra - 28'd1;
          walk_idx_next = AW'(next_idx);
          ram_raddr     = AW'(next_idx);
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    rsp_next.extent_count = count_wide[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      building     <= 1'b0;
      link_cluster <= '0;
      run_index    <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      building     <= building_next;
      link_cluster <= link_cluster_next;
      run_index    <= run_index_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_start <= cur_start_next;
    cur_extra <= cur_extra_next;
    walk_idx  <= walk_idx_next;
    order     <= order_next;
    rsp       <= rsp_next;
  end

endmodule

// ----- design/cluster_chain_extent_table_core.sv -----
// channel   direction  transfer when           payload
// command   in         start && !busy         req  (cmd, value)
// result    out        done (one cycle)       rsp  (status, fetch_cluster, extent_count,
//                                                    mapped_cluster, run_remaining)
// config    in         cfg_we                 cfg_idx, cfg_data
//
// chain commands (start, fat entry, unused) are queued and then taken by the back end,
// which registers their result; it takes one per cycle unless a lookup walk holds it.
// a lookup walks the run table one run per cycle through the store's read port:
// its result comes from the run that hits (or from the last run when the offset is past
// the end); on an empty table it is answered as past the end without a walk.
// busy rises when the two-entry command queue is full; the result side never stalls.
// rst is synchronous and clears the chain state, queue and config; the run store is not
// cleared.
module cluster_chain_extent_table_core #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cce_pkg::req_t  req,
  output logic           done,
  output cce_pkg::rsp_t  rsp,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_idx,
  input  logic [27:0]    cfg_data
);
  import cce_pkg::*;

  logic [27:0] total_clusters;
  logic [2:0]  sector_shift;
  q_head_t     head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_clusters <= '0;
      sector_shift   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TOTAL_CLUSTERS: total_clusters <= cfg_data;
        CFG_CLUSTER_SHIFT:  sector_shift   <= cfg_data[2:0];
        default:            total_clusters <= total_clusters;
      endcase
    end
  end

  cce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .sector_shift (sector_shift),
    .pop          (pop),
    .busy         (busy),
    .head         (head)
  );

  cce_back #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .total_clusters (total_clusters),
    .pop            (pop),
    .done           (done),
    .rsp            (rsp)
  );

endmodule
